FILE: hw/rtl/cprd_pkg.sv
// shared types and constants for the channel packet receive deframer
// no dependencies; imported by every module of the block except cprd_ram
package cprd_pkg;

	localparam int RING_BLOCKS = 32;
	localparam int BLOCK_BYTES = 128;
	localparam int PACKET_ROOM = 16;
	localparam int HDR_LEN     = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam int BLK_W  = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
	localparam int OFF_W  = $clog2(BLOCK_BYTES);
	localparam int FILL_W = $clog2(BLOCK_BYTES - HDR_LEN + 1);
	localparam int ADDR_W = $clog2(RING_BLOCKS * BLOCK_BYTES);
	localparam int CMP_W  = $clog2(BLOCK_BYTES + PACKET_ROOM + HDR_LEN + 1) + 1;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// request kinds on the input channel
	localparam logic [1:0] KIND_WORD = 2'd0;
	localparam logic [1:0] KIND_EOB  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [15:0] NULL_MASK = 16'h80FF;
	localparam int          DATA_BIT  = 15;

	// work handed from the classifier to the executor
	typedef enum logic [2:0] {
		OP_PUT,
		OP_CLOSE,
		OP_CLOSE_NONEMPTY,
		OP_CLOSE_ROOM,
		OP_READ
	} op_code_t;

	typedef struct packed {
		op_code_t    code;
		logic [7:0]  value;
		logic [7:0]  chan;
	} op_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       first;
		logic       last;
		logic       none;
	} res_t;

endpackage

FILE: hw/rtl/channel_packet_receive_deframer_unit.sv
// channel packet receive deframer: top level, front end, op queue and back end
// read requests go through the queue entry, the executor with its ring ram read
// and the result buffer before a result shows; one request per cycle while the queue has room
// throughput is bounded by the single executor, one op per cycle unless a read waits for result buffer room
// asynchronous reset clears all control state; ring ram and block headers are not cleared
// depends on cprd_pkg, cprd_front, cprd_queue, cprd_back, cprd_ram
module channel_packet_receive_deframer_unit import cprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] device_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        block_first,
	output logic        block_last,
	output logic        no_block
);

	logic q_full, q_push, q_pop, q_valid;
	op_t  push_op, head_op;

	cprd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.device_word(device_word),
		.q_full     (q_full),
		.push       (q_push),
		.push_op    (push_op)
	);

	cprd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_op   (head_op)
	);

	cprd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_op    (head_op),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.block_first(block_first),
		.block_last (block_last),
		.no_block   (no_block)
	);

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("executor popped an empty queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("op pushed into a full queue");

	a_no_block_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_block) |-> (out_byte == 8'd0 && !block_first && !block_last))
		else $error("empty-ring result carries block data");

	a_first_last_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(block_first && block_last))
		else $error("block shorter than its header");

endmodule

FILE: hw/rtl/cprd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module cprd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/cprd_front.sv
// front end: accepts requests, tracks packet parsing and channel, emits ops
// depends on cprd_pkg
module cprd_front import cprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] device_word,
	input  logic        q_full,
	output logic        push,
	output op_t         push_op
);

	typedef enum logic [1:0] {
		MODE_CHANNEL,
		MODE_PACKET,
		MODE_SKIP
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] chan_q, chan_d;
	logic       accept;
	logic [7:0] lo;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign lo       = device_word[7:0];

	always_comb begin
		mode_d        = mode_q;
		chan_d        = chan_q;
		push          = 1'b0;
		push_op.code  = OP_PUT;
		push_op.value = lo;
		push_op.chan  = chan_q;
		if (accept) begin
			case (kind)
				KIND_WORD: begin
					if (mode_q == MODE_CHANNEL) begin
						if (lo == 8'd0) begin
							mode_d = MODE_SKIP;
						end else begin
							// channel change closes a block that holds data
							if (lo != chan_q) begin
								push          = 1'b1;
								push_op.code  = OP_CLOSE_NONEMPTY;
								push_op.value = 8'd0;
								chan_d        = lo;
							end
							mode_d = MODE_PACKET;
						end
					end else if ((device_word & NULL_MASK) == 16'd0) begin
						if (mode_q == MODE_PACKET) begin
							push          = 1'b1;
							push_op.code  = OP_CLOSE_ROOM;
							push_op.value = 8'd0;
						end
						mode_d = MODE_CHANNEL;
					end else if (mode_q == MODE_PACKET) begin
						push         = 1'b1;
						push_op.code = device_word[DATA_BIT] ? OP_PUT : OP_CLOSE;
					end
				end
				KIND_EOB: begin
					push          = 1'b1;
					push_op.code  = OP_CLOSE_NONEMPTY;
					push_op.value = 8'd0;
				end
				KIND_READ: begin
					push         = 1'b1;
					push_op.code = OP_READ;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CHANNEL;
			chan_q <= 8'd0;
		end else begin
			mode_q <= mode_d;
			chan_q <= chan_d;
		end
	end

endmodule

FILE: hw/rtl/cprd_queue.sv
// short op queue between the classifier and the executor
// depends on cprd_pkg
module cprd_queue import cprd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	op_t               ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_op    = ent_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

endmodule

FILE: hw/rtl/cprd_back.sv
// back end: block ring bookkeeping, ring ram access and the result buffer
// depends on cprd_pkg and cprd_ram
module cprd_back import cprd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  op_t        head_op,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       block_first,
	output logic       block_last,
	output logic       no_block
);

	localparam logic [ADDR_W-1:0] BB_A = ADDR_W'(BLOCK_BYTES);

	logic [BLK_W-1:0]  write_block_q, read_block_q, next_wb;
	logic [OFF_W-1:0]  read_offset_q;
	logic [FILL_W-1:0] fill_count_q;

	// per-block header and fill, written on close
	logic [7:0]        hdr_chan_q [RING_BLOCKS];
	logic [7:0]        hdr_ctl_q  [RING_BLOCKS];
	logic [FILL_W-1:0] blk_fill_q [RING_BLOCKS];

	logic              is_read, rd_room, do_close, do_put, room_ok, empty;
	logic [FILL_W-1:0] rd_fill;
	logic              rd_last;
	logic [7:0]        hdr_byte;
	logic [1:0]        pending;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_rdata;

	// read pipeline stage
	logic              rd_s2, use_ram_s2, first_s2, last_s2, none_s2;
	logic [7:0]        hdr_s2;
	res_t              res_s2;

	// two-entry result buffer
	res_t              ob_q [2];
	logic              ob_wr_q, ob_rd_q;
	logic [1:0]        ob_cnt_q;
	logic              ob_pop;

	assign ob_pop  = out_valid && out_ready;
	assign pending = ob_cnt_q + {1'b0, rd_s2} - {1'b0, ob_pop};
	assign rd_room = (pending < 2'd2);
	assign is_read = (head_op.code == OP_READ);
	assign pop     = head_valid && (!is_read || rd_room);

	assign room_ok = (CMP_W'(HDR_LEN) + CMP_W'(fill_count_q)) < CMP_W'(BLOCK_BYTES);
	assign do_put  = pop && (head_op.code == OP_PUT) && room_ok;

	always_comb begin
		do_close = 1'b0;
		if (pop) begin
			case (head_op.code)
				OP_CLOSE:          do_close = 1'b1;
				OP_CLOSE_NONEMPTY: do_close = (fill_count_q != '0);
				OP_CLOSE_ROOM:     do_close = (CMP_W'(HDR_LEN) + CMP_W'(fill_count_q)
					+ CMP_W'(PACKET_ROOM)) > CMP_W'(BLOCK_BYTES);
				default:           do_close = 1'b0;
			endcase
		end
	end

	assign next_wb = (write_block_q == BLK_W'(RING_BLOCKS - 1)) ? '0 : write_block_q + 1'b1;
	assign empty   = (read_block_q == write_block_q);
	assign rd_fill = blk_fill_q[read_block_q];
	assign rd_last = (CMP_W'(read_offset_q) == CMP_W'(HDR_LEN - 1) + CMP_W'(rd_fill));

	always_comb begin
		case (read_offset_q)
			OFF_W'(0): hdr_byte = hdr_chan_q[read_block_q];
			OFF_W'(2): hdr_byte = hdr_ctl_q[read_block_q];
			default:   hdr_byte = 8'd0;
		endcase
	end

	// data bytes sit at their block offset; header slots of the ram stay unused
	assign ram_we    = do_put;
	assign ram_waddr = ADDR_W'(write_block_q) * BB_A + ADDR_W'(HDR_LEN)
		+ ADDR_W'(fill_count_q);
	assign ram_re    = pop && is_read && !empty;
	assign ram_raddr = ADDR_W'(read_block_q) * BB_A + ADDR_W'(read_offset_q);

	cprd_ram #(
		.WIDTH(8),
		.DEPTH(RING_BLOCKS * BLOCK_BYTES)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(head_op.value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (do_close) begin
			hdr_chan_q[write_block_q] <= head_op.chan;
			hdr_ctl_q[write_block_q]  <= head_op.value;
			blk_fill_q[write_block_q] <= fill_count_q;
		end
		if (pop && is_read) begin
			hdr_s2     <= empty ? 8'd0 : hdr_byte;
			use_ram_s2 <= !empty && (CMP_W'(read_offset_q) >= CMP_W'(HDR_LEN));
			first_s2   <= !empty && (read_offset_q == '0);
			last_s2    <= !empty && rd_last;
			none_s2    <= empty;
		end
		if (rd_s2) begin
			ob_q[ob_wr_q] <= res_s2;
		end
	end

	assign res_s2.byte_val = use_ram_s2 ? ram_rdata : hdr_s2;
	assign res_s2.first    = first_s2;
	assign res_s2.last     = last_s2;
	assign res_s2.none     = none_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_block_q <= '0;
			read_block_q  <= '0;
			read_offset_q <= '0;
			fill_count_q  <= '0;
			rd_s2         <= 1'b0;
			ob_wr_q       <= 1'b0;
			ob_rd_q       <= 1'b0;
			ob_cnt_q      <= 2'd0;
		end else begin
			if (do_put) begin
				fill_count_q <= fill_count_q + 1'b1;
			end
			if (do_close) begin
				fill_count_q <= '0;
				// ring full: the slot is reused in place
				if (next_wb != read_block_q) begin
					write_block_q <= next_wb;
				end
			end
			if (pop && is_read && !empty) begin
				if (rd_last) begin
					read_offset_q <= '0;
					read_block_q  <= (read_block_q == BLK_W'(RING_BLOCKS - 1)) ? '0
						: read_block_q + 1'b1;
				end else begin
					read_offset_q <= read_offset_q + 1'b1;
				end
			end
			rd_s2 <= pop && is_read;
			if (rd_s2) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			ob_cnt_q <= ob_cnt_q + {1'b0, rd_s2} - {1'b0, ob_pop};
		end
	end

	assign out_valid   = (ob_cnt_q != 2'd0);
	assign out_byte    = ob_q[ob_rd_q].byte_val;
	assign block_first = ob_q[ob_rd_q].first;
	assign block_last  = ob_q[ob_rd_q].last;
	assign no_block    = ob_q[ob_rd_q].none;

endmodule

FILE: bench/channel_packet_receive_deframer_unit_tb.sv
// testbench for channel_packet_receive_deframer_unit: drives fifo words, bursts and reads
// and checks every returned byte against an in-bench block ring predictor
// depends on cprd_pkg and the rtl of the block
module channel_packet_receive_deframer_unit_tb;
	import cprd_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int RANDOM_ITEMS = 1500;
	localparam int STUCK_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [1:0] {
		EXPECT_CHANNEL,
		IN_PACKET,
		SKIP_PACKET
	} parse_mode_t;

	class block_ring_scoreboard;
		logic [7:0]       ring [RING_BLOCKS*BLOCK_BYTES];
		int               blk_len [RING_BLOCKS];
		logic [BLK_W-1:0] wr_blk;
		logic [BLK_W-1:0] rd_blk;
		logic [OFF_W-1:0] rd_off;
		logic [FILL_W-1:0] fill;
		logic [7:0]       chan;
		parse_mode_t      mode;
		res_t             expected_bytes[$];
		int               errors;

		function new();
			wr_blk = '0;
			rd_blk = '0;
			rd_off = '0;
			fill = '0;
			chan = '0;
			mode = EXPECT_CHANNEL;
			errors = 0;
			foreach (blk_len[i]) blk_len[i] = 0;
		endfunction

		function void close_blk(input logic [7:0] ctl);
			int base;
			logic [BLK_W-1:0] nxt;
			base = int'(wr_blk) * BLOCK_BYTES;
			ring[base] = chan;
			ring[base + 1] = 8'h00;
			ring[base + 2] = ctl;
			blk_len[wr_blk] = HDR_LEN + int'(fill);
			nxt = wr_blk + 1'b1;
			// ring full: the slot is reopened empty instead of advancing
			if (nxt != rd_blk)
				wr_blk = nxt;
			fill = '0;
		endfunction

		function void take_word(input logic [15:0] w);
			logic [7:0] lo;
			lo = w[7:0];
			if (mode == EXPECT_CHANNEL) begin
				if (lo == 8'h00) begin
					mode = SKIP_PACKET;
				end else begin
					if (chan != lo) begin
						if (fill != 0)
							close_blk(8'h00);
						chan = lo;
					end
					mode = IN_PACKET;
				end
			end else if ((w & NULL_MASK) == 16'h0000) begin
				if (mode == IN_PACKET && HDR_LEN + int'(fill) + PACKET_ROOM > BLOCK_BYTES)
					close_blk(8'h00);
				mode = EXPECT_CHANNEL;
			end else if (mode == IN_PACKET) begin
				if (!w[DATA_BIT]) begin
					close_blk(lo);
				end else if (HDR_LEN + int'(fill) < BLOCK_BYTES) begin
					// bytes past the end of a full block are dropped
					ring[int'(wr_blk) * BLOCK_BYTES + HDR_LEN + int'(fill)] = lo;
					fill = fill + 1'b1;
				end
			end
		endfunction

		function void read_next();
			res_t r;
			int len;
			int off;
			r = '0;
			if (rd_blk == wr_blk) begin
				r.none = 1'b1;
			end else begin
				len = blk_len[rd_blk];
				if (len < HDR_LEN || len > BLOCK_BYTES)
					len = HDR_LEN;
				off = int'(rd_off);
				if (off >= len)
					off = 0;
				r.byte_val = ring[int'(rd_blk) * BLOCK_BYTES + off];
				r.first = (off == 0);
				r.last = (off + 1 == len);
				if (off + 1 >= len) begin
					rd_off = '0;
					rd_blk = rd_blk + 1'b1;
				end else begin
					rd_off = OFF_W'(off + 1);
				end
			end
			expected_bytes.push_back(r);
		endfunction

		// called for every accepted request
		function void take_request(input logic [1:0] k, input logic [15:0] w);
			case (k)
				KIND_WORD: take_word(w);
				KIND_EOB: begin
					if (fill != 0)
						close_blk(8'h00);
				end
				KIND_READ: read_next();
				default: ;
			endcase
		endfunction

		function void compare(input string name, input int want, input int got);
			if (want != got) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(input res_t got);
			res_t want;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result with nothing pending, expected none actual %0h",
						$time, got);
				return;
			end
			want = expected_bytes.pop_front();
			compare("out_byte", int'(want.byte_val), int'(got.byte_val));
			compare("block_first", int'(want.first), int'(got.first));
			compare("block_last", int'(want.last), int'(got.last));
			compare("no_block", int'(want.none), int'(got.none));
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [15:0] device_word;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        block_first;
	logic        block_last;
	logic        no_block;

	block_ring_scoreboard sb = new();
	int sent;
	int stuck_cycles;
	bit in_rush;
	bit out_rush;

	channel_packet_receive_deframer_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.device_word (device_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.block_first (block_first),
		.block_last  (block_last),
		.no_block    (no_block)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_request(kind, device_word);
			if (out_valid && out_ready)
				sb.check_result({out_byte, block_first, block_last, no_block});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck_cycles = 0;
			else
				stuck_cycles = stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, STUCK_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones, none at all during a rush
	function automatic int idle_len(input bit rush);
		int r;
		r = $urandom_range(0, 99);
		if (rush || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic drive_result_ready();
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					hold = idle_len(out_rush);
			end
		end
	endtask

	task automatic send_req(input logic [1:0] k, input logic [15:0] w);
		int gap;
		gap = idle_len(in_rush);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		device_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (k != KIND_IGNORED)
			sent++;
	endtask

	// channel word, body, null word; a few are long to fill a block, a few lose their null
	task automatic send_packet(input int read_pct);
		logic [7:0] ch;
		int n;
		int r;
		bit long_run;
		r = $urandom_range(0, 99);
		if (r < 15)
			ch = 8'h00;
		else if (r < 60)
			ch = 8'($urandom_range(1, 3));
		else
			ch = 8'($urandom_range(1, 255));
		send_req(KIND_WORD, {8'($urandom), ch});
		long_run = ($urandom_range(0, 19) == 0);
		if (long_run)
			n = $urandom_range(95, 140);
		else if ($urandom_range(0, 99) < 70)
			n = $urandom_range(0, 6);
		else
			n = $urandom_range(7, 30);
		repeat (n) begin
			r = long_run ? 99 : $urandom_range(0, 99);
			if (r < read_pct)
				send_req(KIND_READ, 16'($urandom));
			else if (r < read_pct + 4)
				send_req(KIND_EOB, 16'($urandom));
			else if (r < read_pct + 14)
				send_req(KIND_WORD, {1'b0, 7'($urandom), 8'($urandom_range(1, 255))});
			else
				send_req(KIND_WORD, {1'b1, 7'($urandom), 8'($urandom)});
		end
		if ($urandom_range(0, 19) != 0)
			send_req(KIND_WORD, {1'b0, 7'($urandom), 8'h00});
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_WORD;
		device_word = 16'h0000;
		out_ready = 1'b0;
		in_rush = 1'b0;
		out_rush = 1'b0;
		sent = 0;
		stuck_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drive_result_ready();
		join_none

		// nothing stored yet, then an ignored kind
		send_req(KIND_READ, 16'h0000);
		send_req(KIND_IGNORED, 16'hFFFF);
		// channel 5, two data bytes at the extremes, closed by a control byte
		send_req(KIND_WORD, 16'h0005);
		send_req(KIND_WORD, 16'h80FF);
		send_req(KIND_WORD, 16'h8000);
		send_req(KIND_WORD, 16'h7F81);
		send_req(KIND_WORD, 16'h7F00);
		// channel change, end of burst mid packet closes it, second burst does nothing
		send_req(KIND_WORD, 16'hFFFF);
		send_req(KIND_WORD, 16'h80AA);
		send_req(KIND_EOB, 16'hFFFF);
		send_req(KIND_EOB, 16'h0000);
		send_req(KIND_WORD, 16'h0000);
		// channel 0 packet is skipped up to its null word
		send_req(KIND_WORD, 16'h8000);
		send_req(KIND_WORD, 16'h8012);
		send_req(KIND_WORD, 16'h0033);
		send_req(KIND_WORD, 16'h7F00);
		// control byte on an empty block
		send_req(KIND_WORD, 16'h0007);
		send_req(KIND_WORD, 16'h0001);
		send_req(KIND_WORD, 16'h0000);
		repeat (6) send_req(KIND_READ, 16'h0000);

		while (sent < RANDOM_ITEMS) begin
			in_rush = ($urandom_range(0, 4) == 0);
			out_rush = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 6))
				0, 1: begin
					// no reads, so the ring runs full
					repeat ($urandom_range(15, 40)) begin
						send_packet(0);
						if ($urandom_range(0, 1) != 0)
							send_req(KIND_EOB, 16'($urandom));
					end
				end
				2, 3: repeat ($urandom_range(20, 150)) send_req(KIND_READ, 16'($urandom));
				4, 5: repeat ($urandom_range(3, 10)) send_packet(30);
				default: repeat ($urandom_range(5, 20)) send_req(2'($urandom), 16'($urandom));
			endcase
		end
		in_valid <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
